FILE: hw/rtl/olist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg
// shared constants, types and helpers for the ordered list engine
// ----------------------------------------------------------------------------
package olist_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int SUM_W      = CNT_W + 1;

	localparam int MODE_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 5;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REM_FRONT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REM_BACK  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REM_VALUE = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic                     we;
		idx_t                     waddr;
		logic signed [VALUE_W-1:0] wdata;
		idx_t                     raddr;
	} mem_req_t;

	// physical slot of a logical position, ring buffer starting at head
	function automatic idx_t slot_of(input idx_t head, input logic [SUM_W-1:0] pos);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(head) + pos;
		if (sum >= SUM_W'(LIST_DEPTH)) begin
			sum = sum - SUM_W'(LIST_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// bounded ordered list of signed 32-bit values with front/back insert and
// remove, remove by value and search
// ----------------------------------------------------------------------------
// sequence: inserts go from the accepting edge straight to the done step, remove
//   front/back pass through the pop step, search and remove by value walk the list
//   entry by entry in the scan step and a removal ahead of the back entry refills
//   in the shift step; the result register loads from the done step
// handshake: one request at a time, s_tready low from accept until the result
//   loads; a stalled result holds the engine in the done step
// reset: entry count, head and output valid clear, list empty; the entry store
//   is not cleared, entries beyond the count are never used
module ordered_list_engine
	import olist_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // mode[2:0], value[34:3], zero fill
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata    // status[1:0], removed_value[33:2],
	                                       // position[38:34], zero fill
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	state_t                    state_q;
	idx_t                      head_q;      // physical slot of the front entry
	logic [CNT_W-1:0]          count_q;     // entries held
	idx_t                      cmp_idx_q;   // logical position under compare
	idx_t                      sh_idx_q;    // logical position being refilled
	logic [MODE_W-1:0]         mode_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [STATUS_W-1:0]       res_status_q;
	logic signed [VALUE_W-1:0] res_removed_q;
	logic [POS_W-1:0]          res_pos_q;
	logic                      m_tvalid_q;
	logic [M_DATA_W-1:0]       m_tdata_q;

	mem_req_t                  mem_req;
	logic signed [VALUE_W-1:0] mem_rdata;

	logic [MODE_W-1:0]         in_mode;
	logic signed [VALUE_W-1:0] in_value;
	logic                      in_accept;
	logic                      list_full;
	logic                      list_empty;
	logic                      last_cmp;    // compare position is the back entry
	logic                      last_shift;  // refill reaches the back entry
	logic                      hit;
	logic                      res_load;    // done step hands its result over
	idx_t                      head_dec;
	idx_t                      head_inc;
	logic [SUM_W-1:0]          cmp_next;
	logic [SUM_W-1:0]          pos_sum;

	assign in_mode    = s_tdata[MODE_W-1:0];
	assign in_value   = s_tdata[MODE_W +: VALUE_W];
	assign s_tready   = (state_q == ST_IDLE);
	assign in_accept  = s_tvalid && s_tready;

	assign list_full  = (count_q == CNT_W'(LIST_DEPTH));
	assign list_empty = (count_q == '0);
	assign cmp_next   = SUM_W'(cmp_idx_q) + SUM_W'(1);
	assign last_cmp   = (cmp_next == SUM_W'(count_q));
	assign last_shift = ((SUM_W'(sh_idx_q) + SUM_W'(2)) == SUM_W'(count_q));
	assign hit        = (mem_rdata == val_q);
	assign res_load   = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign head_dec   = (head_q == '0) ? IDX_W'(LIST_DEPTH - 1) : head_q - IDX_W'(1);
	assign head_inc   = slot_of(head_q, SUM_W'(1));
	assign pos_sum    = cmp_next;

	// store port: writes for inserts and refill, reads run one step ahead
	always_comb begin
		mem_req       = '0;
		mem_req.wdata = in_value;
		case (state_q)
			ST_IDLE: begin
				if (in_mode == MODE_REM_BACK) begin
					mem_req.raddr = slot_of(head_q, SUM_W'(count_q) - SUM_W'(1));
				end else begin
					mem_req.raddr = head_q;
				end
				if (in_accept && !list_full) begin
					if (in_mode == MODE_INS_FRONT) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = head_dec;
					end else if (in_mode == MODE_INS_BACK) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = slot_of(head_q, SUM_W'(count_q));
					end
				end
			end
			ST_SCAN: begin
				mem_req.raddr = slot_of(head_q, cmp_next);
			end
			ST_SHIFT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = slot_of(head_q, SUM_W'(sh_idx_q));
				mem_req.wdata = mem_rdata;
				mem_req.raddr = slot_of(head_q, SUM_W'(sh_idx_q) + SUM_W'(2));
			end
			default: begin
				mem_req.raddr = head_q;
			end
		endcase
	end

	olist_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// sequencer, list pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			head_q        <= '0;
			count_q       <= '0;
			cmp_idx_q     <= '0;
			sh_idx_q      <= '0;
			mode_q        <= '0;
			val_q         <= '0;
			res_status_q  <= STATUS_OK;
			res_removed_q <= '0;
			res_pos_q     <= '0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			// output register: load from the done step, else drop once taken
			if (res_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {{(M_DATA_W - STATUS_W - VALUE_W - POS_W){1'b0}},
				               res_pos_q, res_removed_q, res_status_q};
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						mode_q        <= in_mode;
						val_q         <= in_value;
						res_status_q  <= STATUS_OK;
						res_removed_q <= '0;
						res_pos_q     <= '0;
						cmp_idx_q     <= '0;
						state_q       <= ST_DONE;
						case (in_mode)
							MODE_INS_FRONT: begin
								if (list_full) begin
									res_status_q <= STATUS_FULL;
								end else begin
									head_q  <= head_dec;
									count_q <= count_q + CNT_W'(1);
								end
							end
							MODE_INS_BACK: begin
								if (list_full) begin
									res_status_q <= STATUS_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							MODE_REM_FRONT, MODE_REM_BACK: begin
								if (list_empty) begin
									res_status_q <= STATUS_EMPTY;
								end else begin
									state_q <= ST_POP;
								end
							end
							MODE_REM_VALUE, MODE_SEARCH: begin
								if (list_empty) begin
									res_status_q <= STATUS_EMPTY;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								// unused codes: no operation
							end
						endcase
					end
				end
				ST_POP: begin
					res_removed_q <= mem_rdata;
					count_q       <= count_q - CNT_W'(1);
					if (mode_q == MODE_REM_FRONT) begin
						head_q <= head_inc;
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (hit) begin
						if (mode_q == MODE_SEARCH) begin
							res_pos_q <= pos_sum[POS_W-1:0];
							state_q   <= ST_DONE;
						end else begin
							res_removed_q <= val_q;
							if (last_cmp) begin
								count_q <= count_q - CNT_W'(1);
								state_q <= ST_DONE;
							end else begin
								// the entry behind the hit is already being read
								sh_idx_q <= cmp_idx_q;
								state_q  <= ST_SHIFT;
							end
						end
					end else if (last_cmp) begin
						res_status_q <= STATUS_NOTFOUND;
						state_q      <= ST_DONE;
					end else begin
						cmp_idx_q <= cmp_next[IDX_W-1:0];
					end
				end
				ST_SHIFT: begin
					if (last_shift) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_DONE;
					end else begin
						sh_idx_q <= sh_idx_q + IDX_W'(1);
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks on the sequencer and list bookkeeping
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LIST_DEPTH))
		else $error("entry count beyond depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (SUM_W'(cmp_idx_q) < SUM_W'(count_q)))
		else $error("compare position beyond the list");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> ((SUM_W'(sh_idx_q) + SUM_W'(1)) < SUM_W'(count_q)))
		else $error("refill position beyond the list");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the done step");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && !hit && !last_cmp |=> $stable(count_q))
		else $error("count changed during a walk without a hit");

endmodule

FILE: hw/rtl/olist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_mem
// entry store, one write and one registered read port
// ----------------------------------------------------------------------------
module olist_mem
	import olist_pkg::*;
(
	input  logic                      clk,
	input  mem_req_t                  req,
	output logic signed [VALUE_W-1:0] rdata
);

	logic signed [VALUE_W-1:0] mem_q [LIST_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata <= mem_q[req.raddr];
	end

endmodule

FILE: tb/sv/list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_checker
// watches the request and result streams of the ordered list engine, keeps a
// shadow copy of the list, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module list_checker
	import olist_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	output int                  fail_count,
	output int                  pending
);

	typedef struct {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] removed;
		logic [POS_W-1:0]          position;
	} list_result_t;

	logic signed [VALUE_W-1:0] shadow_list[$];
	list_result_t              awaited_results[$];
	int                        result_index = 0;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("list_checker: result %0d: %s", result_index, msg);
		fail_count = fail_count + 1;
	endtask

	// applies one request to the shadow list and returns what the engine should say
	function automatic list_result_t apply_request(input logic [MODE_W-1:0] mode,
	                                               input logic signed [VALUE_W-1:0] value);
		list_result_t r;
		int           hit;
		r.status   = STATUS_OK;
		r.removed  = '0;
		r.position = '0;
		hit        = -1;
		// first match from the front, used by remove value and search
		for (int i = 0; i < shadow_list.size(); i++) begin
			if (hit < 0 && shadow_list[i] == value) begin
				hit = i;
			end
		end
		case (mode)
			MODE_INS_FRONT, MODE_INS_BACK: begin
				if (shadow_list.size() >= LIST_DEPTH) begin
					r.status = STATUS_FULL;
				end else if (mode == MODE_INS_FRONT) begin
					shadow_list.push_front(value);
				end else begin
					shadow_list.push_back(value);
				end
			end
			MODE_REM_FRONT: begin
				if (shadow_list.size() == 0) r.status = STATUS_EMPTY;
				else r.removed = shadow_list.pop_front();
			end
			MODE_REM_BACK: begin
				if (shadow_list.size() == 0) r.status = STATUS_EMPTY;
				else r.removed = shadow_list.pop_back();
			end
			MODE_REM_VALUE: begin
				if (shadow_list.size() == 0) begin
					r.status = STATUS_EMPTY;
				end else if (hit < 0) begin
					r.status = STATUS_NOTFOUND;
				end else begin
					r.removed = shadow_list[hit];
					shadow_list.delete(hit);
				end
			end
			MODE_SEARCH: begin
				if (shadow_list.size() == 0) r.status = STATUS_EMPTY;
				else if (hit < 0) r.status = STATUS_NOTFOUND;
				else r.position = POS_W'(hit + 1);
			end
			default: begin
				// spare codes do nothing
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		list_result_t              want;
		logic [STATUS_W-1:0]       got_status;
		logic signed [VALUE_W-1:0] got_removed;
		logic [POS_W-1:0]          got_position;
		if (arst_n) begin
			// results first, a request accepted on the same edge is never its source
			if (m_tvalid && m_tready) begin
				got_status   = m_tdata[STATUS_W-1:0];
				got_removed  = m_tdata[STATUS_W +: VALUE_W];
				got_position = m_tdata[STATUS_W + VALUE_W +: POS_W];
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0h", m_tdata));
				end else begin
					want = awaited_results.pop_front();
					if (got_status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							got_status, want.status));
					if (got_removed !== want.removed)
						report_mismatch($sformatf("removed value %0d, want %0d",
							got_removed, want.removed));
					if (got_position !== want.position)
						report_mismatch($sformatf("position %0d, want %0d",
							got_position, want.position));
				end
				result_index = result_index + 1;
			end
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(apply_request(s_tdata[MODE_W-1:0],
					s_tdata[MODE_W +: VALUE_W]));
			end
			pending = awaited_results.size();
		end
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the ordered list engine: directed corner requests,
// then random phases that swing the list between empty and full, with random
// gaps on the request side and random stalls on the result side
// ----------------------------------------------------------------------------
module tb;
	import olist_pkg::*;

	// spare operation codes, the engine must answer them with a plain ok
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	localparam int RANDOM_REQUESTS = 420;
	// 450 requests at the longest gap, walk and stall each still fit many times over
	localparam int CYCLE_LIMIT     = 200000;
	// longest walk of the engine plus a little slack
	localparam int SETTLE_CYCLES   = LIST_DEPTH + 4;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;

	int fail_count;
	int pending;
	int cycle_count = 0;
	// when set, neither side idles: back to back stretches
	logic no_gaps = 1'b0;

	// small set of values so that searches and removals by value hit often,
	// extremes and duplicates included
	logic signed [VALUE_W-1:0] value_pool [8] = '{
		32'sd0, -32'sd1, 32'sd1, 32'sh7FFF_FFFF,
		32'sh8000_0000, 32'sd5, -32'sd5, 32'sh55AA_55AA
	};

	ordered_list_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	list_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// watchdog, a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random stall before each result, none while no_gaps is set
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_gaps ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// one request; called at a falling edge and returns at a falling edge,
	// so tvalid gets a single update per step
	task automatic send_request(input logic [MODE_W-1:0] mode,
	                            input logic signed [VALUE_W-1:0] value);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			// junk on the bus while tvalid is low, must be ignored
			s_tdata  <= S_DATA_W'({$urandom, $urandom});
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W - MODE_W - VALUE_W){1'b0}}, value, mode};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// hold off new requests until every awaited result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// random request, fill_bias sets the share of inserts in percent
	task automatic send_random_request(input int fill_bias);
		logic [MODE_W-1:0]         mode;
		logic signed [VALUE_W-1:0] value;
		if ($urandom_range(0, 99) < 3) begin
			mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
		end else if ($urandom_range(0, 99) < fill_bias) begin
			mode = $urandom_range(0, 1) ? MODE_INS_BACK : MODE_INS_FRONT;
		end else begin
			case ($urandom_range(0, 3))
				0:       mode = MODE_REM_FRONT;
				1:       mode = MODE_REM_BACK;
				2:       mode = MODE_REM_VALUE;
				default: mode = MODE_SEARCH;
			endcase
		end
		// mostly pool values so lookups hit, the rest full-width random
		if ($urandom_range(0, 9) < 6) value = value_pool[$urandom_range(0, 7)];
		else value = $urandom;
		send_request(mode, value);
	endtask

	initial begin : stimulus
		int sent;
		int phase;
		int phase_len;
		int fill_bias;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every remove and search on the empty list, then the spare codes
		send_request(MODE_REM_FRONT, 32'sd0);
		send_request(MODE_REM_BACK, 32'sd0);
		send_request(MODE_REM_VALUE, 32'sd0);
		send_request(MODE_SEARCH, 32'sd0);
		send_request(MODE_SPARE_LO, 32'sh7FFF_FFFF);
		send_request(MODE_SPARE_HI, 32'sh8000_0000);

		// fill to the brim from both ends, each pool value twice
		for (int i = 0; i < LIST_DEPTH; i++) begin
			send_request(i[0] ? MODE_INS_BACK : MODE_INS_FRONT, value_pool[i % 8]);
		end
		// inserts on a full list
		send_request(MODE_INS_FRONT, 32'sd123);
		send_request(MODE_INS_BACK, 32'sd456);

		// duplicates: hit nearest the front; misses; then both ends
		send_request(MODE_SEARCH, 32'sh8000_0000);
		send_request(MODE_SEARCH, 32'sd99);
		send_request(MODE_REM_VALUE, -32'sd1);
		send_request(MODE_REM_VALUE, 32'sd99);
		send_request(MODE_REM_FRONT, 32'sd0);
		send_request(MODE_REM_BACK, 32'sd0);

		wait_drained();

		// random phases, each leaning towards full, towards empty or neither
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_REQUESTS) begin
			phase_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0:       fill_bias = 80;
				1:       fill_bias = 20;
				default: fill_bias = 50;
			endcase
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++) begin
				send_random_request(fill_bias);
				sent++;
			end
			if (phase == 2) wait_drained();
			phase++;
		end
		no_gaps = 1'b0;

		// let everything come back, then give the engine time for a stray result
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/olist_pkg.sv
hw/rtl/olist_mem.sv
hw/rtl/ordered_list_engine.sv
tb/sv/list_checker.sv
tb/sv/tb.sv
